// File: hdl/qwck_pkg.sv
// shared constants, quality factor table and base decoding for the k-mer block
package qwck_pkg;

    // field and state widths
    localparam int CHAR_W     = 8;
    localparam int K_W        = 5;
    localparam int FACTOR_W   = 16;
    localparam int DIVISOR_W  = 17;
    localparam int PROD_W     = 64;
    localparam int MAX_K_DEF  = 31;
    localparam int WIN_DEPTH  = 32;
    localparam int WIN_AW     = 5;

    // divider: the top quotient bits are known zero because any factor is at least 2^14
    localparam int MULT_W     = PROD_W + FACTOR_W;
    localparam int ZERO_QBITS = 14;
    localparam int DIV_STEPS  = MULT_W - ZERO_QBITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [K_W-1:0]       KLEN_RESET     = K_W'(22);
    localparam logic [PROD_W-1:0]    ONE_Q63        = {1'b1, {(PROD_W-1){1'b0}}};
    localparam logic [FACTOR_W-1:0]  FLOOR_Q16      = 16'd16384;
    localparam logic [FACTOR_W-1:0]  FACTOR_MAX     = 16'hFFFF;
    localparam logic [DIVISOR_W-1:0] ONE_Q16        = 17'h10000;
    localparam logic [CHAR_W-1:0]    QUAL_OFFSET    = 8'd33;
    localparam int                   QUAL_ENTRIES   = 47;

    // base characters and their 2-bit codes
    localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_UG = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_UT = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_LG = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_LT = 8'h74;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;
    localparam logic [1:0] CODE_COMP = 2'b11;

    // quality factor max(0.25, 1 - 10^(-q/10)) in Q0.16 for q = 0..46
    localparam logic [FACTOR_W-1:0] QUAL_ROM [QUAL_ENTRIES] = '{
        16'd16384, 16'd16384, 16'd24186, 16'd32690, 16'd39446, 16'd44812, 16'd49074,
        16'd52460, 16'd55149, 16'd57286, 16'd58982, 16'd60330, 16'd61401, 16'd62251,
        16'd62927, 16'd63464, 16'd63890, 16'd64228, 16'd64497, 16'd64711, 16'd64881,
        16'd65015, 16'd65122, 16'd65208, 16'd65275, 16'd65329, 16'd65371, 16'd65405,
        16'd65432, 16'd65453, 16'd65470, 16'd65484, 16'd65495, 16'd65503, 16'd65510,
        16'd65515, 16'd65520, 16'd65523, 16'd65526, 16'd65528, 16'd65529, 16'd65531,
        16'd65532, 16'd65533, 16'd65533, 16'd65534, 16'd65534
    };

    // quality character to Q0.16 factor
    function automatic logic [FACTOR_W-1:0] factor_of(input logic [CHAR_W-1:0] q);
        logic [CHAR_W-1:0] rel;
        rel = q - QUAL_OFFSET;
        if (q < QUAL_OFFSET)
            return FLOOR_Q16;
        else if (rel >= CHAR_W'(QUAL_ENTRIES))
            return FACTOR_MAX;
        else
            return QUAL_ROM[rel[5:0]];
    endfunction

    // base character to 2-bit code, anything unknown codes as A
    function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] c);
        logic [1:0] code;
        case (c)
            CHAR_UA, CHAR_LA: code = CODE_A;
            CHAR_UC, CHAR_LC: code = CODE_C;
            CHAR_UG, CHAR_LG: code = CODE_G;
            CHAR_UT, CHAR_LT: code = CODE_T;
            default:          code = CODE_A;
        endcase
        return code;
    endfunction

    // uppercase ACGT only
    function automatic logic base_good(input logic [CHAR_W-1:0] c);
        return (c == CHAR_UA) || (c == CHAR_UC) || (c == CHAR_UG) || (c == CHAR_UT);
    endfunction

endpackage

// File: hdl/qwck_ram.sv
// generic single-write, single-read ram with registered read data
module qwck_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/qwck_muldiv.sv
// sequential capped floor(p * f / d) in Q1.63: shared 32x16 multiplier, restoring divide
module qwck_muldiv (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [qwck_pkg::PROD_W-1:0]        p,
    input  logic [qwck_pkg::FACTOR_W-1:0]      f,
    input  logic [qwck_pkg::DIVISOR_W-1:0]     d,
    output logic                               done,
    output logic [qwck_pkg::PROD_W-1:0]        result
);
    import qwck_pkg::*;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL_HI,
        MD_DIV,
        MD_DONE
    } md_state_t;

    localparam int HALF_W = PROD_W / 2;
    localparam int PP_W   = HALF_W + FACTOR_W;
    localparam int NUM_W  = DIV_STEPS;

    md_state_t               state_reg;
    logic [HALF_W-1:0]       p_hi_reg;
    logic [FACTOR_W-1:0]     f_reg;
    logic [DIVISOR_W-1:0]    d_reg;
    logic [PP_W-1:0]         lo_reg;
    logic [DIVISOR_W-1:0]    rem_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [STEP_W-1:0]       step_reg;

    logic [HALF_W-1:0]       mul_a;
    logic [FACTOR_W-1:0]     mul_b;
    logic [PP_W-1:0]         mul_out;
    logic [MULT_W-1:0]       sum;
    logic [DIVISOR_W:0]      shifted;
    logic [DIVISOR_W:0]      trial;
    logic                    borrow;
    logic [DIVISOR_W-1:0]    rem_next;
    logic [NUM_W-1:0]        num_next;

    // one multiplier, low half of p at start, high half in the next cycle
    assign mul_a   = (state_reg == MD_IDLE) ? p[HALF_W-1:0] : p_hi_reg;
    assign mul_b   = (state_reg == MD_IDLE) ? f : f_reg;
    assign mul_out = PP_W'(mul_a) * PP_W'(mul_b);

    // full product from the two partial products
    assign sum = MULT_W'(lo_reg) + {mul_out, {HALF_W{1'b0}}};

    // one restoring divide step
    assign shifted  = {rem_reg, num_reg[NUM_W-1]};
    assign trial    = shifted - {1'b0, d_reg};
    assign borrow   = trial[DIVISOR_W];
    assign rem_next = borrow ? shifted[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    assign num_next = {num_reg[NUM_W-2:0], ~borrow};

    // quotient capped at 1.0
    assign done   = (state_reg == MD_DONE);
    assign result = (num_reg > NUM_W'(ONE_Q63)) ? ONE_Q63 : num_reg[PROD_W-1:0];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            step_reg  <= '0;
            p_hi_reg  <= '0;
            f_reg     <= '0;
            d_reg     <= '0;
            lo_reg    <= '0;
            rem_reg   <= '0;
            num_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                MD_IDLE:
                begin
                    if (start)
                    begin
                        p_hi_reg  <= p[PROD_W-1:HALF_W];
                        f_reg     <= f;
                        d_reg     <= d;
                        lo_reg    <= mul_out;
                        state_reg <= MD_MUL_HI;
                    end
                end
                MD_MUL_HI:
                begin
                    rem_reg   <= DIVISOR_W'(sum[MULT_W-1:NUM_W]);
                    num_reg   <= sum[NUM_W-1:0];
                    step_reg  <= '0;
                    state_reg <= MD_DIV;
                end
                MD_DIV:
                begin
                    rem_reg  <= rem_next;
                    num_reg  <= num_next;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= MD_DONE;
                    end
                end
                MD_DONE:
                begin
                    state_reg <= MD_IDLE;
                end
                default:
                begin
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/quality_weighted_canonical_kmer.sv
// top level: rolling canonical k-mer extraction with quality-weighted window product
//
//  port group   direction  handshake             payload
//  in           sink       in_valid / in_ready   base_char, quality_char, read_start
//  out          source     out_valid / out_ready canonical_kmer, weight, from_reverse
//  cfg          sink       cfg_valid / cfg_ready cfg_data (k-mer length)
//
// An item occupies the block from its accept through the fetch, calc and emit states;
// the calc time is set by the shared 32x16 multiplier and the bit-serial divider (66 steps).
// An item with no result frees the block without passing through the emit state.
// Reset is asynchronous; it clears the rolling state and loads the k-mer length with 22.
// A finished result waits in the output register; a stalled output only holds
// the block once the next result is ready to be loaded.
module quality_weighted_canonical_kmer #(
    parameter int MAX_K = qwck_pkg::MAX_K_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [qwck_pkg::CHAR_W-1:0]     base_char,
    input  logic [qwck_pkg::CHAR_W-1:0]     quality_char,
    input  logic                            read_start,
    // results
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2*MAX_K-1:0]              canonical_kmer,
    output logic [qwck_pkg::PROD_W-1:0]     weight,
    output logic                            from_reverse,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qwck_pkg::K_W-1:0]        cfg_data
);
    import qwck_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CALC,
        ST_EMIT
    } state_t;

    localparam int KMER_W = 2 * MAX_K;
    localparam int TOP_W  = K_W + 1;

    state_t                  state_reg;
    logic [K_W-1:0]          klen_reg;
    logic [KMER_W-1:0]       fwd_reg;
    logic [KMER_W-1:0]       rev_reg;
    logic [K_W-1:0]          mask_reg;
    logic [K_W-1:0]          seen_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [WIN_AW-1:0]       win_pos_reg;
    logic [FACTOR_W-1:0]     factor_reg;
    logic                    full_reg;
    logic                    emit_reg;
    logic                    out_valid_reg;
    logic [KMER_W-1:0]       kmer_out_reg;
    logic [PROD_W-1:0]       weight_out_reg;
    logic                    rev_out_reg;

    logic                    in_xfer;
    logic [K_W-1:0]          k_eff;
    logic [TOP_W-1:0]        top;
    logic [KMER_W-1:0]       fmask;
    logic [1:0]              code;
    logic                    good;
    logic [FACTOR_W-1:0]     factor_in;
    logic [KMER_W-1:0]       fwd_start;
    logic [KMER_W-1:0]       rev_start;
    logic [K_W-1:0]          seen_start;
    logic [K_W-1:0]          mask_start;
    logic [KMER_W-1:0]       fwd_next;
    logic [KMER_W-1:0]       rev_next;
    logic [K_W-1:0]          seen_next;
    logic [K_W-1:0]          mask_next;
    logic                    full_next;
    logic                    emit_next;
    logic [WIN_AW-1:0]       rd_addr;
    logic [FACTOR_W-1:0]     win_rdata;
    logic [DIVISOR_W-1:0]    divisor;
    logic                    md_start;
    logic                    md_done;
    logic [PROD_W-1:0]       md_result;
    logic                    out_free;
    logic                    pick_rev;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // effective k clamped to 1..MAX_K
    always_comb
    begin
        if (klen_reg == '0)
            k_eff = K_W'(1);
        else if (klen_reg > K_W'(MAX_K))
            k_eff = K_W'(MAX_K);
        else
            k_eff = klen_reg;
    end

    assign top   = {k_eff, 1'b0} - TOP_W'(2);
    assign fmask = (KMER_W'(1) << top) - KMER_W'(1);

    // decode the incoming base and quality
    assign code      = base_code(base_char);
    assign good      = base_good(base_char);
    assign factor_in = factor_of(quality_char);

    // rolling state, cleared first when a read starts
    assign fwd_start  = read_start ? '0 : fwd_reg;
    assign rev_start  = read_start ? '0 : rev_reg;
    assign seen_start = read_start ? '0 : seen_reg;
    assign mask_start = read_start ? '0 : mask_reg;

    assign fwd_next  = ((fwd_start & fmask) << 2) | KMER_W'(code);
    assign rev_next  = (rev_start >> 2) | (KMER_W'(CODE_COMP ^ code) << top);
    assign full_next = (seen_start >= k_eff);
    assign seen_next = (seen_start < k_eff) ? seen_start + K_W'(1) : k_eff;

    // countdown that blocks k-mers covering a bad base
    always_comb
    begin
        if (!good)
            mask_next = k_eff;
        else if (mask_start != '0)
            mask_next = mask_start - K_W'(1);
        else
            mask_next = '0;
    end

    assign emit_next = (seen_next >= k_eff) && (mask_next == '0);

    // factor window: write the new factor, read the one leaving the window
    assign rd_addr = win_pos_reg - WIN_AW'(k_eff);

    qwck_ram #(
        .WIDTH (FACTOR_W),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (win_pos_reg),
        .wdata (factor_in),
        .re    (in_xfer),
        .raddr (rd_addr),
        .rdata (win_rdata)
    );

    // divisor: outgoing factor once the window is full, otherwise 1.0
    assign divisor  = (full_reg && (win_rdata != '0)) ? DIVISOR_W'(win_rdata) : ONE_Q16;
    assign md_start = (state_reg == ST_FETCH);

    qwck_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .p      (prod_reg),
        .f      (factor_reg),
        .d      (divisor),
        .done   (md_done),
        .result (md_result)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign pick_rev = !(fwd_reg < rev_reg);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_reg <= KLEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            klen_reg <= cfg_data;
        end
    end

    // sequencer, rolling state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fwd_reg        <= '0;
            rev_reg        <= '0;
            mask_reg       <= '0;
            seen_reg       <= '0;
            prod_reg       <= ONE_Q63;
            win_pos_reg    <= '0;
            factor_reg     <= '0;
            full_reg       <= 1'b0;
            emit_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            kmer_out_reg   <= '0;
            weight_out_reg <= '0;
            rev_out_reg    <= 1'b0;
        end
        else
        begin
            // output valid: set on a new result, cleared when the result is taken
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        fwd_reg     <= fwd_next;
                        rev_reg     <= rev_next;
                        seen_reg    <= seen_next;
                        mask_reg    <= mask_next;
                        full_reg    <= full_next;
                        emit_reg    <= emit_next;
                        factor_reg  <= factor_in;
                        win_pos_reg <= win_pos_reg + WIN_AW'(1);
                        if (read_start)
                        begin
                            prod_reg <= ONE_Q63;
                        end
                        state_reg   <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    if (md_done)
                    begin
                        prod_reg  <= md_result;
                        state_reg <= emit_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        kmer_out_reg   <= pick_rev ? rev_reg : fwd_reg;
                        weight_out_reg <= prod_reg;
                        rev_out_reg    <= pick_rev;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign canonical_kmer = kmer_out_reg;
    assign weight         = weight_out_reg;
    assign from_reverse   = rev_out_reg;

    // checks
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("block took an item while still busy");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == ST_CALC))
        else $error("divider finished outside the calc state");

    a_weight_capped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (weight_out_reg <= ONE_Q63))
        else $error("weight above 1.0");

    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> (seen_reg <= k_eff))
        else $error("base count beyond k");

endmodule

// File: sim/tb_quality_weighted_canonical_kmer.sv
// testbench for the quality-weighted canonical k-mer extractor
`timescale 1ns / 100ps

module tb_quality_weighted_canonical_kmer;

    import qwck_pkg::*;

    localparam int KMER_W        = 2 * MAX_K_DEF;
    localparam int SETTLE_CYCLES = 80;
    localparam int QUIET_LIMIT   = 2000;

    // characters that are not bases
    localparam logic [CHAR_W-1:0] CHAR_N   = 8'h4E;
    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TOP = 8'hFF;

    // phred factor table, q = 0..46, Q0.16
    localparam logic [FACTOR_W-1:0] PHRED_FACTOR [QUAL_ENTRIES] = '{
        16'd16384, 16'd16384, 16'd24186, 16'd32690, 16'd39446, 16'd44812, 16'd49074,
        16'd52460, 16'd55149, 16'd57286, 16'd58982, 16'd60330, 16'd61401, 16'd62251,
        16'd62927, 16'd63464, 16'd63890, 16'd64228, 16'd64497, 16'd64711, 16'd64881,
        16'd65015, 16'd65122, 16'd65208, 16'd65275, 16'd65329, 16'd65371, 16'd65405,
        16'd65432, 16'd65453, 16'd65470, 16'd65484, 16'd65495, 16'd65503, 16'd65510,
        16'd65515, 16'd65520, 16'd65523, 16'd65526, 16'd65528, 16'd65529, 16'd65531,
        16'd65532, 16'd65533, 16'd65533, 16'd65534, 16'd65534
    };

    typedef struct packed {
        logic [KMER_W-1:0] kmer;
        logic [PROD_W-1:0] weight;
        logic              from_rev;
    } kmer_hit_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CHAR_W-1:0]   base_char;
    logic [CHAR_W-1:0]   quality_char;
    logic                read_start;
    logic                out_valid;
    logic                out_ready;
    logic [KMER_W-1:0]   canonical_kmer;
    logic [PROD_W-1:0]   weight;
    logic                from_reverse;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [K_W-1:0]      cfg_data;

    // predicted block state
    logic [K_W-1:0]      klen_m;
    logic [KMER_W-1:0]   fwd_kmer;
    logic [KMER_W-1:0]   rc_kmer;
    int                  mask_left;
    int                  read_bases;
    logic [PROD_W-1:0]   window_weight;
    logic [FACTOR_W-1:0] factor_ring [WIN_DEPTH];
    logic [WIN_AW-1:0]   ring_pos;

    kmer_hit_t           expected_hits[$];
    int                  errors;
    int                  items_sent;
    int                  quiet_cycles;
    bit                  sender_idles;
    int                  burst_left;
    int                  stall_mode;
    int                  stall_span;

    quality_weighted_canonical_kmer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .base_char      (base_char),
        .quality_char   (quality_char),
        .read_start     (read_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .canonical_kmer (canonical_kmer),
        .weight         (weight),
        .from_reverse   (from_reverse),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int effective_k(input logic [K_W-1:0] len);
        int k;
        k = int'(len);
        if (k < 1)
            k = 1;
        if (k > MAX_K_DEF)
            k = MAX_K_DEF;
        return k;
    endfunction

    function automatic logic [FACTOR_W-1:0] phred_factor(input logic [CHAR_W-1:0] q);
        int rel;
        rel = int'(q) - int'(QUAL_OFFSET);
        if (rel < 0)
            return FLOOR_Q16;
        if (rel >= QUAL_ENTRIES)
            return FACTOR_MAX;
        return PHRED_FACTOR[rel];
    endfunction

    function automatic logic [1:0] base_to_code(input logic [CHAR_W-1:0] c);
        logic [1:0] code;
        case (c)
            CHAR_UA, CHAR_LA: code = CODE_A;
            CHAR_UC, CHAR_LC: code = CODE_C;
            CHAR_UG, CHAR_LG: code = CODE_G;
            CHAR_UT, CHAR_LT: code = CODE_T;
            default:          code = CODE_A;
        endcase
        return code;
    endfunction

    // roll one base into the k-mers and the window weight, queue the hit if any
    task automatic roll_base(input logic [CHAR_W-1:0] b, input logic [CHAR_W-1:0] q,
                             input logic first);
        int                  k;
        int                  top;
        logic [1:0]          code;
        logic [KMER_W-1:0]   keep_mask;
        logic [FACTOR_W-1:0] f;
        logic [DIVISOR_W-1:0] divisor;
        logic [127:0]        scaled;
        logic [WIN_AW-1:0]   out_pos;
        logic                upper;
        kmer_hit_t           hit;
        k = effective_k(klen_m);
        top = 2 * k - 2;
        code = base_to_code(b);
        f = phred_factor(q);
        upper = (b == CHAR_UA) || (b == CHAR_UC) || (b == CHAR_UG) || (b == CHAR_UT);
        if (first)
        begin
            fwd_kmer = '0;
            rc_kmer = '0;
            mask_left = 0;
            read_bases = 0;
            window_weight = ONE_Q63;
        end
        keep_mask = (KMER_W'(1) << top) - KMER_W'(1);
        fwd_kmer = ((fwd_kmer & keep_mask) << 2) | KMER_W'(code);
        rc_kmer = (rc_kmer >> 2) | (KMER_W'(CODE_COMP ^ code) << top);
        // once the window is full the outgoing factor is divided out
        divisor = ONE_Q16;
        if (read_bases >= k)
        begin
            out_pos = ring_pos - WIN_AW'(k);
            if (factor_ring[out_pos] != '0)
                divisor = DIVISOR_W'(factor_ring[out_pos]);
        end
        scaled = ({64'd0, window_weight} * 128'(f)) / 128'(divisor);
        window_weight = (scaled > 128'(ONE_Q63)) ? ONE_Q63 : scaled[PROD_W-1:0];
        factor_ring[ring_pos] = f;
        ring_pos = ring_pos + WIN_AW'(1);
        read_bases = (read_bases < k) ? read_bases + 1 : k;
        if (!upper)
            mask_left = k;
        else if (mask_left > 0)
            mask_left--;
        if (read_bases >= k && mask_left == 0)
        begin
            hit.from_rev = !(fwd_kmer < rc_kmer);
            hit.kmer = hit.from_rev ? rc_kmer : fwd_kmer;
            hit.weight = window_weight;
            expected_hits.insert(expected_hits.size(), hit);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [PROD_W-1:0] got,
                                   input logic [PROD_W-1:0] want);
        $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin
        kmer_hit_t hit;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                klen_m = cfg_data;
            if (in_valid && in_ready)
                roll_base(base_char, quality_char, read_start);
            if (out_valid && out_ready)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch("unexpected result kmer", 64'(canonical_kmer), '0);
                else
                begin
                    hit = expected_hits.pop_front();
                    if (canonical_kmer !== hit.kmer)
                        report_mismatch("canonical_kmer", 64'(canonical_kmer), 64'(hit.kmer));
                    if (weight !== hit.weight)
                        report_mismatch("weight", weight, hit.weight);
                    if (from_reverse !== hit.from_rev)
                        report_mismatch("from_reverse", 64'(from_reverse), 64'(hit.from_rev));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side backpressure, one of four patterns, each held for a random span
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_span = $urandom_range(50, 300);
            stall_mode = $urandom_range(0, 3);
        end
        stall_span--;
        case (stall_mode)
            0: out_ready = 1'b1;
            1: out_ready = 1'($urandom_range(0, 1));
            2: out_ready = ($urandom_range(0, 7) != 0);
            default: out_ready = ((stall_span % 24) < 4);
        endcase
    end

    // one input transfer; returns at a falling edge
    task automatic send_base(input logic [CHAR_W-1:0] b, input logic [CHAR_W-1:0] q,
                             input logic first);
        int gap;
        in_valid = 1'b1;
        base_char = b;
        quality_char = q;
        read_start = first;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        @(negedge clk);
        if (sender_idles)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 8);
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // stop sending, wait for every hit and for the last item to finish
    task automatic settle_block();
        in_valid = 1'b0;
        while (expected_hits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write while the block is idle
    task automatic set_klen(input logic [K_W-1:0] len);
        cfg_valid = 1'b1;
        cfg_data = len;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] random_quality();
        int sel;
        logic [CHAR_W-1:0] q;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            q = CHAR_W'($urandom_range(33, 80));
        else if (sel < 9)
            q = CHAR_W'($urandom_range(0, 255));
        else
        begin
            case ($urandom_range(0, 5))
                0: q = 8'd0;
                1: q = 8'd32;
                2: q = 8'd33;
                3: q = 8'd79;
                4: q = 8'd80;
                default: q = 8'd255;
            endcase
        end
        return q;
    endfunction

    function automatic logic [CHAR_W-1:0] random_base(input int bad_odds);
        logic [CHAR_W-1:0] b;
        if ($urandom_range(1, bad_odds) == 1)
        begin
            case ($urandom_range(0, 5))
                0: b = CHAR_LA;
                1: b = CHAR_LC;
                2: b = CHAR_LG;
                3: b = CHAR_LT;
                4: b = CHAR_N;
                default: b = CHAR_W'($urandom_range(0, 255));
            endcase
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: b = CHAR_UA;
                1: b = CHAR_UC;
                2: b = CHAR_UG;
                default: b = CHAR_UT;
            endcase
        end
        return b;
    endfunction

    // mostly whole reads, some noise and cut-short reads
    task automatic run_read_stream(input int n);
        int first_item;
        int k;
        int len;
        int kind;
        first_item = items_sent;
        k = effective_k(klen_m);
        while (items_sent - first_item < n)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                len = k + $urandom_range(0, 40);
                for (int i = 0; i < len; i++)
                    send_base(random_base(30), random_quality(), i == 0);
            end
            else if (kind == 8)
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    send_base(CHAR_W'($urandom_range(0, 255)), CHAR_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
            else
            begin
                len = $urandom_range(1, k);
                for (int i = 0; i < len; i++)
                    send_base(random_base(4), random_quality(), i == 0);
            end
        end
        settle_block();
    endtask

    // reset length: a single base cannot fill a 22-base window
    task automatic test_reset_length();
        send_base(CHAR_UA, 8'd73, 1'b1);
        settle_block();
    endtask

    // zero length acts as one base; quality extremes and masking characters
    task automatic test_unit_length();
        set_klen(5'd0);
        send_base(CHAR_UA, 8'd0, 1'b1);
        send_base(CHAR_UC, 8'd255, 1'b0);
        send_base(CHAR_UG, 8'd33, 1'b0);
        send_base(CHAR_UT, 8'd79, 1'b0);
        send_base(CHAR_LA, 8'd80, 1'b0);
        send_base(CHAR_UT, 8'd32, 1'b0);
        send_base(CHAR_NUL, 8'd40, 1'b0);
        send_base(CHAR_TOP, 8'd50, 1'b0);
        send_base(CHAR_N, 8'd60, 1'b0);
        send_base(CHAR_UG, 8'd34, 1'b1);
        settle_block();
    endtask

    // two bases: palindromes tie and pick the reverse strand
    task automatic test_palindrome();
        set_klen(5'd2);
        send_base(CHAR_UA, 8'd60, 1'b1);
        send_base(CHAR_UT, 8'd60, 1'b0);
        send_base(CHAR_UG, 8'd70, 1'b0);
        send_base(CHAR_UC, 8'd70, 1'b0);
        send_base(CHAR_LC, 8'd70, 1'b0);
        send_base(CHAR_UG, 8'd45, 1'b0);
        send_base(CHAR_UC, 8'd36, 1'b0);
        settle_block();
    endtask

    // length changes without a new read
    task automatic test_length_change();
        set_klen(5'd1);
        send_base(CHAR_UA, 8'd50, 1'b0);
        send_base(CHAR_UC, 8'd38, 1'b0);
        settle_block();
        set_klen(5'd3);
        send_base(CHAR_UG, 8'd66, 1'b0);
        send_base(CHAR_UT, 8'd42, 1'b0);
        send_base(CHAR_UA, 8'd55, 1'b0);
        settle_block();
    endtask

    task automatic test_longest_kmer();
        set_klen(5'd31);
        run_read_stream(300);
    endtask

    task automatic test_shortest_kmer();
        set_klen(5'd1);
        run_read_stream(200);
        set_klen(5'd0);
        run_read_stream(100);
    endtask

    task automatic test_default_length();
        set_klen(KLEN_RESET);
        run_read_stream(300);
    endtask

    // random lengths, the sender idles only in some phases
    task automatic test_mixed_lengths();
        for (int p = 0; p < 5; p++)
        begin
            sender_idles = (p % 2 == 0);
            set_klen(K_W'($urandom_range(1, 31)));
            run_read_stream(200);
        end
        sender_idles = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        base_char = '0;
        quality_char = '0;
        read_start = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        klen_m = KLEN_RESET;
        fwd_kmer = '0;
        rc_kmer = '0;
        mask_left = 0;
        read_bases = 0;
        window_weight = ONE_Q63;
        ring_pos = '0;
        for (int i = 0; i < WIN_DEPTH; i++)
            factor_ring[i] = '0;
        errors = 0;
        items_sent = 0;
        quiet_cycles = 0;
        sender_idles = 1'b1;
        burst_left = 0;
        stall_mode = 0;
        stall_span = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_length();
        test_unit_length();
        test_palindrome();
        test_length_change();
        test_longest_kmer();
        test_shortest_kmer();
        test_default_length();
        test_mixed_lengths();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
hdl/qwck_pkg.sv
hdl/qwck_ram.sv
hdl/qwck_muldiv.sv
hdl/quality_weighted_canonical_kmer.sv
sim/tb_quality_weighted_canonical_kmer.sv
